### hw/rtl/sst_pkg.sv
package sst_pkg;

    // Storage geometry
    localparam int KEY_SPACE   = 1024;
    localparam int DENSE_DEPTH = 256;
    localparam int HANDLE_BITS = 32;

    localparam int KEY_BITS   = $clog2(KEY_SPACE);
    localparam int SLOT_BITS  = $clog2(DENSE_DEPTH);
    localparam int COUNT_BITS = $clog2(DENSE_DEPTH + 1);

    // Field widths of the channels
    localparam int CMD_BITS         = 2;
    localparam int ITEM_KEY_BITS    = 10;
    localparam int ITEM_HANDLE_BITS = 32;
    localparam int STATUS_BITS      = 2;
    localparam int FOUND_BITS       = 32;
    localparam int ENTRY_COUNT_BITS = 9;

    // Configuration port
    localparam int ID_LIMIT_BITS  = 10;
    localparam int CAP_LIMIT_BITS = 9;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [ID_LIMIT_BITS-1:0]  ID_LIMIT_RESET  = 10'd1023;
    localparam logic [CAP_LIMIT_BITS-1:0] CAP_LIMIT_RESET = 9'd256;

    // Register index, taken from the word address bit
    localparam logic REG_ID_LIMIT  = 1'b0;
    localparam logic REG_CAP_LIMIT = 1'b1;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_SEARCH = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd3;

    // Status codes
    localparam logic [STATUS_BITS-1:0] STS_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] STS_MISS = 2'd1;
    localparam logic [STATUS_BITS-1:0] STS_FULL = 2'd2;
    localparam logic [STATUS_BITS-1:0] STS_DUP  = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic sparse_rd;
        logic dense_rd;
        logic execute;
    } sst_ctrl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
        logic item_held;
    } sst_stat_t;

endpackage

### hw/rtl/sst_intf.sv
// Command channel: one beat carries one command.
interface sst_cmd_if
    import sst_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [CMD_BITS-1:0]         cmd;
    logic [ITEM_KEY_BITS-1:0]    item_key;
    logic [ITEM_HANDLE_BITS-1:0] item_handle;

    modport source (output valid, cmd, item_key, item_handle, input ready);
    modport sink (input valid, cmd, item_key, item_handle, output ready);
endinterface

// Response channel: one beat per command.
interface sst_rsp_if
    import sst_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [STATUS_BITS-1:0]      status;
    logic [FOUND_BITS-1:0]       found_handle;
    logic [ENTRY_COUNT_BITS-1:0] entry_count;

    modport source (output valid, status, found_handle, entry_count, input ready);
    modport sink (input valid, status, found_handle, entry_count, output ready);
endinterface

### hw/rtl/sparse_set_table.sv
// Channel  Direction  Beat carries
// req      in         cmd, item_key, item_handle
// rsp      out        status, found_handle, entry_count
// apb      in/out     id_limit at 0x0, capacity_limit at 0x4
//
// Each command passes through accept, sparse memory read, dense memory read
// (two ports) and execute with the memory writes, in the order set by the
// chain of dependent memory reads; a new command waits until the last executes.
// Reset clears the count, sets id_limit to 1023 and capacity_limit to 256;
// memory words are never cleared, since a key is a member only when its slot
// is below the count and the dense key matches.
// A response waits in the output register while the next command is accepted;
// that command holds in its execute step until the register is free.
module sparse_set_table
    import sst_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    sst_cmd_if.sink                  req,
    sst_rsp_if.source                rsp,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic [ID_LIMIT_BITS-1:0]  id_limit;
    logic [CAP_LIMIT_BITS-1:0] capacity_limit;
    sst_ctrl_t                 ctrl;
    sst_stat_t                 stat;

    // Configuration registers
    sst_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .id_limit       (id_limit),
        .capacity_limit (capacity_limit)
    );

    // Command sequencer
    sst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // Memories, count and response register
    sst_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .stat           (stat),
        .id_limit       (id_limit),
        .capacity_limit (capacity_limit),
        .in_cmd         (req.cmd),
        .in_key         (req.item_key),
        .in_handle      (req.item_handle),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_status     (rsp.status),
        .out_found      (rsp.found_handle),
        .out_count      (rsp.entry_count)
    );

endmodule

### hw/rtl/sst_cfg.sv
module sst_cfg
    import sst_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_BITS-1:0]  paddr,
    input  logic [CFG_DATA_BITS-1:0]  pwdata,
    output logic [CFG_DATA_BITS-1:0]  prdata,
    output logic                      pready,
    output logic [ID_LIMIT_BITS-1:0]  id_limit,
    output logic [CAP_LIMIT_BITS-1:0] capacity_limit
);

    logic                      wr_en;
    logic [ID_LIMIT_BITS-1:0]  id_limit_reg;
    logic [CAP_LIMIT_BITS-1:0] cap_limit_reg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Registers are decoded on the word address bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_limit_reg  <= ID_LIMIT_RESET;
            cap_limit_reg <= CAP_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_ID_LIMIT:  id_limit_reg  <= pwdata[ID_LIMIT_BITS-1:0];
                REG_CAP_LIMIT: cap_limit_reg <= pwdata[CAP_LIMIT_BITS-1:0];
                default:       id_limit_reg  <= id_limit_reg;
            endcase
        end
    end

    // Read back; a misaligned read returns zero.
    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            unique case (paddr[2])
                REG_ID_LIMIT:  prdata = CFG_DATA_BITS'(id_limit_reg);
                REG_CAP_LIMIT: prdata = CFG_DATA_BITS'(cap_limit_reg);
                default:       prdata = '0;
            endcase
        end
    end

    assign id_limit       = id_limit_reg;
    assign capacity_limit = cap_limit_reg;

endmodule

### hw/rtl/sst_ctrl.sv
module sst_ctrl
    import sst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sst_stat_t stat,
    output sst_ctrl_t ctrl
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOOKUP = 2'd1;
    localparam logic [1:0] S_FETCH  = 2'd2;
    localparam logic [1:0] S_EXEC   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Sequence one command through sparse read, dense read and execute.
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load_item = 1'b1;
                    state_next     = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                ctrl.sparse_rd = 1'b1;
                state_next     = S_FETCH;
            end
            S_FETCH:
            begin
                ctrl.dense_rd = 1'b1;
                state_next    = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    ctrl.execute = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An executed command always returns the sequencer to idle.
    a_exec_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.execute |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle after execute");

    // The datapath holds an item whenever the sequencer is past idle.
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> stat.item_held)
        else $error("sequencer busy without a held item");

endmodule

### hw/rtl/sst_datapath.sv
module sst_datapath
    import sst_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  sst_ctrl_t                   ctrl,
    output sst_stat_t                   stat,
    input  logic [ID_LIMIT_BITS-1:0]    id_limit,
    input  logic [CAP_LIMIT_BITS-1:0]   capacity_limit,
    input  logic [CMD_BITS-1:0]         in_cmd,
    input  logic [ITEM_KEY_BITS-1:0]    in_key,
    input  logic [ITEM_HANDLE_BITS-1:0] in_handle,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [STATUS_BITS-1:0]      out_status,
    output logic [FOUND_BITS-1:0]       out_found,
    output logic [ENTRY_COUNT_BITS-1:0] out_count
);

    // Held command
    logic [CMD_BITS-1:0]         cmd_reg;
    logic [ITEM_KEY_BITS-1:0]    key_reg;
    logic [ITEM_HANDLE_BITS-1:0] handle_reg;
    logic                        held_reg;

    // Set state
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    // Memories and their registered read data
    logic [SLOT_BITS-1:0]   sparse_mem [KEY_SPACE];
    logic [KEY_BITS-1:0]    dkey_mem [DENSE_DEPTH];
    logic [HANDLE_BITS-1:0] dhandle_mem [DENSE_DEPTH];
    logic [SLOT_BITS-1:0]   sparse_q;
    logic [KEY_BITS-1:0]    hit_key_q;
    logic [KEY_BITS-1:0]    last_key_q;
    logic [HANDLE_BITS-1:0] hit_handle_q;
    logic [HANDLE_BITS-1:0] last_handle_q;

    // Write ports
    logic                   sparse_we;
    logic [KEY_BITS-1:0]    sparse_waddr;
    logic [SLOT_BITS-1:0]   sparse_wdata;
    logic                   dense_we;
    logic [SLOT_BITS-1:0]   dense_waddr;
    logic [KEY_BITS-1:0]    dense_wkey;
    logic [HANDLE_BITS-1:0] dense_whandle;

    // Execute decision
    logic [KEY_BITS-1:0]    key_idx;
    logic [SLOT_BITS-1:0]   last_slot;
    logic [COUNT_BITS-1:0]  cap;
    logic                   key_ok;
    logic                   hit;
    logic [STATUS_BITS-1:0] status_next;
    logic [FOUND_BITS-1:0]  found_next;

    // Output register
    logic                        out_valid_reg;
    logic [STATUS_BITS-1:0]      status_reg;
    logic [FOUND_BITS-1:0]       found_reg;
    logic [ENTRY_COUNT_BITS-1:0] count_out_reg;

    assign key_idx   = key_reg[KEY_BITS-1:0];
    assign last_slot = SLOT_BITS'(count_reg - COUNT_BITS'(1));
    assign cap       = (COUNT_BITS'(capacity_limit) < COUNT_BITS'(DENSE_DEPTH)) ?
                       COUNT_BITS'(capacity_limit) : COUNT_BITS'(DENSE_DEPTH);
    assign key_ok    = (key_reg <= id_limit) && (int'(key_reg) < KEY_SPACE);
    assign hit       = (COUNT_BITS'(sparse_q) < count_reg) && (hit_key_q == key_idx);

    // Capture the accepted command.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            cmd_reg    <= in_cmd;
            key_reg    <= in_key;
            handle_reg <= in_handle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else if (ctrl.load_item)
        begin
            held_reg <= 1'b1;
        end
        else if (ctrl.execute)
        begin
            held_reg <= 1'b0;
        end
    end

    // Sparse memory: key to dense slot.
    always_ff @(posedge clk)
    begin
        if (sparse_we)
        begin
            sparse_mem[sparse_waddr] <= sparse_wdata;
        end
        if (ctrl.sparse_rd)
        begin
            sparse_q <= sparse_mem[key_idx];
        end
    end

    // Dense memory: two read ports for the hit slot and the last slot.
    always_ff @(posedge clk)
    begin
        if (dense_we)
        begin
            dkey_mem[dense_waddr]    <= dense_wkey;
            dhandle_mem[dense_waddr] <= dense_whandle;
        end
        if (ctrl.dense_rd)
        begin
            hit_key_q     <= dkey_mem[sparse_q];
            hit_handle_q  <= dhandle_mem[sparse_q];
            last_key_q    <= dkey_mem[last_slot];
            last_handle_q <= dhandle_mem[last_slot];
        end
    end

    // Decide status, memory writes and the new count.
    always_comb
    begin
        status_next   = STS_OK;
        found_next    = '0;
        count_next    = count_reg;
        sparse_we     = 1'b0;
        sparse_waddr  = key_idx;
        sparse_wdata  = SLOT_BITS'(count_reg);
        dense_we      = 1'b0;
        dense_waddr   = SLOT_BITS'(count_reg);
        dense_wkey    = key_idx;
        dense_whandle = handle_reg[HANDLE_BITS-1:0];
        if (cmd_reg == CMD_CLEAR)
        begin
            count_next = '0;
        end
        else if (!key_ok)
        begin
            status_next = STS_MISS;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_INSERT:
                begin
                    if (hit)
                    begin
                        status_next = STS_DUP;
                    end
                    else if (count_reg >= cap)
                    begin
                        status_next = STS_FULL;
                    end
                    else
                    begin
                        sparse_we  = ctrl.execute;
                        dense_we   = ctrl.execute;
                        count_next = count_reg + COUNT_BITS'(1);
                    end
                end
                CMD_DELETE:
                begin
                    if (hit)
                    begin
                        // Move the last pair into the freed slot and repoint it.
                        dense_we      = ctrl.execute;
                        dense_waddr   = sparse_q;
                        dense_wkey    = last_key_q;
                        dense_whandle = last_handle_q;
                        sparse_we     = ctrl.execute;
                        sparse_waddr  = last_key_q;
                        sparse_wdata  = sparse_q;
                        count_next    = count_reg - COUNT_BITS'(1);
                    end
                    else
                    begin
                        status_next = STS_MISS;
                    end
                end
                CMD_SEARCH:
                begin
                    if (hit)
                    begin
                        found_next = FOUND_BITS'(hit_handle_q);
                    end
                    else
                    begin
                        status_next = STS_MISS;
                    end
                end
                default:
                begin
                    count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.execute)
        begin
            count_reg <= count_next;
        end
    end

    // Output register: a finished beat waits here for the sink.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.execute)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.execute)
        begin
            status_reg    <= status_next;
            found_reg     <= found_next;
            count_out_reg <= ENTRY_COUNT_BITS'(count_next);
        end
    end

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.item_held = held_reg;
    assign out_valid      = out_valid_reg;
    assign out_status     = status_reg;
    assign out_found      = found_reg;
    assign out_count      = count_out_reg;

    // The count never exceeds the dense depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(DENSE_DEPTH))
        else $error("entry count above dense depth");

    // A successful insert grows the count by one.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.execute && cmd_reg == CMD_INSERT && status_next == STS_OK
        |=> count_reg == $past(count_reg) + COUNT_BITS'(1))
        else $error("insert did not grow the count");

    // A nonzero handle is only ever returned with an ok status.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && found_reg != '0 |-> status_reg == STS_OK)
        else $error("handle returned with a failing status");

    // Execute is only issued while the output register can take the beat.
    a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.execute |-> stat.out_free && held_reg)
        else $error("execute without room or without an item");

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import sst_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [STATUS_BITS-1:0]      status;
        logic [FOUND_BITS-1:0]       found_handle;
        logic [ENTRY_COUNT_BITS-1:0] entry_count;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    sst_cmd_if req_if ();
    sst_rsp_if rsp_if ();

    sparse_set_table dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if.sink),
        .rsp     (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the table contents and limits.
    logic [SLOT_BITS-1:0]        key_slot [KEY_SPACE];
    logic [KEY_BITS-1:0]         dense_key [DENSE_DEPTH];
    logic [HANDLE_BITS-1:0]      dense_handle [DENSE_DEPTH];
    logic [COUNT_BITS-1:0]       held_count;
    logic [ID_LIMIT_BITS-1:0]    key_ceiling;
    logic [CAP_LIMIT_BITS-1:0]   slot_ceiling;

    reply_t replies_due [$];
    reply_t head_reply;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int cycles = 0;
    int mismatches = 0;
    int beats_sent = 0;
    int replies_checked = 0;
    int full_seen = 0;
    int dup_seen = 0;
    int hits_seen = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one command to the shadow table and returns the reply it causes.
    function automatic reply_t table_update(input logic [CMD_BITS-1:0] cmd,
                                            input logic [ITEM_KEY_BITS-1:0] key,
                                            input logic [ITEM_HANDLE_BITS-1:0] handle);
        reply_t r;
        logic [SLOT_BITS-1:0] s;
        logic [SLOT_BITS-1:0] last;
        logic [KEY_BITS-1:0] moved;
        logic [COUNT_BITS-1:0] usable;
        logic held;
        r.status = STS_OK;
        r.found_handle = '0;
        usable = (slot_ceiling > 9'(DENSE_DEPTH)) ? 9'(DENSE_DEPTH) : slot_ceiling;
        s = key_slot[key];
        held = ({1'b0, s} < held_count) && (dense_key[s] == key);
        if (cmd == CMD_CLEAR)
        begin
            held_count = '0;
        end
        else if (key > key_ceiling)
        begin
            r.status = STS_MISS;
        end
        else if (cmd == CMD_INSERT)
        begin
            if (held)
                r.status = STS_DUP;
            else if (held_count >= usable)
                r.status = STS_FULL;
            else
            begin
                dense_key[held_count[SLOT_BITS-1:0]] = key;
                dense_handle[held_count[SLOT_BITS-1:0]] = handle;
                key_slot[key] = held_count[SLOT_BITS-1:0];
                held_count = held_count + COUNT_BITS'(1);
            end
        end
        else if (cmd == CMD_DELETE)
        begin
            if (!held)
                r.status = STS_MISS;
            else
            begin
                // The last pair fills the hole and its sparse word follows it.
                last = SLOT_BITS'(held_count - COUNT_BITS'(1));
                moved = dense_key[last];
                dense_key[s] = moved;
                dense_handle[s] = dense_handle[last];
                key_slot[moved] = s;
                held_count = held_count - COUNT_BITS'(1);
            end
        end
        else
        begin
            if (held)
                r.found_handle = dense_handle[s];
            else
                r.status = STS_MISS;
        end
        r.entry_count = held_count;
        return r;
    endfunction

    // Response side: random ready, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Every response beat is matched against the oldest outstanding reply.
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("response beat with no command outstanding");
                mismatches++;
            end
            else
            begin
                head_reply = replies_due.pop_front();
                if (rsp_if.status !== head_reply.status)
                begin
                    $error("status: expected %0d, got %0d", head_reply.status, rsp_if.status);
                    mismatches++;
                end
                if (rsp_if.found_handle !== head_reply.found_handle)
                begin
                    $error("found_handle: expected 0x%08h, got 0x%08h",
                           head_reply.found_handle, rsp_if.found_handle);
                    mismatches++;
                end
                if (rsp_if.entry_count !== head_reply.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           head_reply.entry_count, rsp_if.entry_count);
                    mismatches++;
                end
                if (head_reply.status == STS_FULL)
                    full_seen++;
                if (head_reply.status == STS_DUP)
                    dup_seen++;
                if (head_reply.found_handle != '0)
                    hits_seen++;
                replies_checked++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d replies outstanding",
                     cycles, replies_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offers one command beat and records its reply once it is taken.
    task automatic send_beat(input logic [CMD_BITS-1:0] cmd,
                             input logic [ITEM_KEY_BITS-1:0] key,
                             input logic [ITEM_HANDLE_BITS-1:0] handle);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd <= cmd;
        req_if.item_key <= key;
        req_if.item_handle <= handle;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        replies_due.push_back(table_update(cmd, key, handle));
        beats_sent++;
    endtask

    // Stops offering, waits for every reply, then lets the block settle.
    task automatic drain(input int settle);
        req_if.valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Register write over the configuration port, done with the block idle.
    task automatic reg_write(input logic idx, input logic [CFG_DATA_BITS-1:0] value);
        drain(8);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_ID_LIMIT)
            key_ceiling = value[ID_LIMIT_BITS-1:0];
        else
            slot_ceiling = value[CAP_LIMIT_BITS-1:0];
    endtask

    // Field extremes, every command, check ordering and lowered limits.
    task automatic test_directed();
        send_beat(CMD_SEARCH, 10'd0, 32'h0);
        send_beat(CMD_DELETE, 10'd0, 32'h0);
        send_beat(CMD_INSERT, 10'd0, 32'h0000_0000);
        send_beat(CMD_INSERT, 10'd1023, 32'hFFFF_FFFF);
        send_beat(CMD_INSERT, 10'd0, 32'h1234_5678);
        send_beat(CMD_SEARCH, 10'd1023, 32'h0);
        // Deleting the first slot moves the last pair down.
        send_beat(CMD_DELETE, 10'd0, 32'h0);
        send_beat(CMD_SEARCH, 10'd1023, 32'h0);
        send_beat(CMD_SEARCH, 10'd0, 32'h0);
        send_beat(CMD_DELETE, 10'd1023, 32'h0);
        send_beat(CMD_CLEAR, 10'd1023, 32'hFFFF_FFFF);
        // A cleared key must not be found through its stale words.
        send_beat(CMD_INSERT, 10'd5, 32'hA5A5_5A5A);
        send_beat(CMD_CLEAR, 10'd0, 32'h0);
        send_beat(CMD_SEARCH, 10'd5, 32'h0);

        // Zero capacity and the smallest key range.
        reg_write(REG_ID_LIMIT, 32'd0);
        reg_write(REG_CAP_LIMIT, 32'd0);
        send_beat(CMD_INSERT, 10'd0, 32'h1);
        send_beat(CMD_SEARCH, 10'd0, 32'h0);
        send_beat(CMD_INSERT, 10'd1, 32'h2);

        // Duplicate is reported ahead of full.
        reg_write(REG_ID_LIMIT, 32'd3);
        reg_write(REG_CAP_LIMIT, 32'd1);
        send_beat(CMD_INSERT, 10'd3, 32'hDEAD_BEEF);
        send_beat(CMD_INSERT, 10'd3, 32'h0);
        send_beat(CMD_INSERT, 10'd2, 32'h0);

        // A held key above a lowered range is refused, then found again.
        reg_write(REG_ID_LIMIT, 32'd2);
        send_beat(CMD_SEARCH, 10'd3, 32'h0);
        send_beat(CMD_DELETE, 10'd3, 32'h0);
        reg_write(REG_ID_LIMIT, 32'd1023);
        reg_write(REG_CAP_LIMIT, 32'd256);
        send_beat(CMD_SEARCH, 10'd3, 32'h0);
        send_beat(CMD_DELETE, 10'd3, 32'h0);
        send_beat(CMD_CLEAR, 10'd0, 32'h0);
    endtask

    // Capacity register above the dense depth: the table fills to its depth.
    task automatic test_fill();
        reg_write(REG_ID_LIMIT, 32'd1023);
        reg_write(REG_CAP_LIMIT, 32'd511);
        send_beat(CMD_CLEAR, 10'd0, 32'h0);
        for (int i = 0; i < DENSE_DEPTH; i++)
            send_beat(CMD_INSERT, 10'(4 * i + 1), $urandom);
        send_beat(CMD_INSERT, 10'd1022, $urandom);
        send_beat(CMD_INSERT, 10'd1, $urandom);
        for (int i = 0; i < DENSE_DEPTH; i += 2)
            send_beat(CMD_DELETE, 10'(4 * i + 1), 32'h0);
        for (int i = DENSE_DEPTH - 1; i >= 0; i--)
            send_beat(CMD_SEARCH, 10'(4 * i + 1), 32'h0);
    endtask

    // Random commands, mostly on a narrow window of keys so that hits,
    // duplicates and full tables are common; the rest hit any key.
    task automatic test_random_mix(input int items, input int key_hi, input int span);
        int base;
        int pick;
        logic [CMD_BITS-1:0] cmd;
        logic [ITEM_KEY_BITS-1:0] key;
        base = $urandom_range(key_hi - span);
        for (int n = 0; n < items; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 38)
                cmd = CMD_INSERT;
            else if (pick < 62)
                cmd = CMD_DELETE;
            else if (pick < 98)
                cmd = CMD_SEARCH;
            else
                cmd = CMD_CLEAR;
            if ($urandom_range(99) < 85)
                key = 10'(base + $urandom_range(span));
            else
                key = 10'($urandom_range(1023));
            send_beat(cmd, key, $urandom);
        end
    endtask

    // Long receiver hold-off so the block backs up, then a full pause.
    task automatic test_backpressure();
        hold_left = 200;
        for (int n = 0; n < 24; n++)
            send_beat(n[0] ? CMD_SEARCH : CMD_INSERT, 10'($urandom_range(31)), $urandom);
        drain(0);
        for (int n = 0; n < 16; n++)
            send_beat(n[0] ? CMD_DELETE : CMD_SEARCH, 10'($urandom_range(31)), $urandom);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.cmd <= CMD_SEARCH;
        req_if.item_key <= '0;
        req_if.item_handle <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        for (int i = 0; i < KEY_SPACE; i++)
            key_slot[i] = '0;
        for (int i = 0; i < DENSE_DEPTH; i++)
        begin
            dense_key[i] = '0;
            dense_handle[i] = '0;
        end
        held_count = '0;
        key_ceiling = ID_LIMIT_RESET;
        slot_ceiling = CAP_LIMIT_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 24;
        recv_idle_pct = 60;
        test_directed();
        reg_write(REG_ID_LIMIT, 32'd1023);
        reg_write(REG_CAP_LIMIT, 32'd256);
        test_random_mix(300, 1023, 48);

        send_idle_pct = 60;
        recv_idle_pct = 24;
        test_fill();
        reg_write(REG_ID_LIMIT, 32'd600);
        reg_write(REG_CAP_LIMIT, 32'd20);
        test_random_mix(300, 600, 40);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        reg_write(REG_ID_LIMIT, 32'd1023);
        reg_write(REG_CAP_LIMIT, 32'd511);
        test_backpressure();
        test_random_mix(300, 1023, 300);

        drain(16);
        $display("Checked %0d replies to %0d commands in %0d cycles",
                 replies_checked, beats_sent, cycles);
        $display("Replies seen: %0d full, %0d duplicate, %0d nonzero handles",
                 full_seen, dup_seen, hits_seen);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
hw/rtl/sst_pkg.sv
hw/rtl/sst_intf.sv
hw/rtl/sst_cfg.sv
hw/rtl/sst_ctrl.sv
hw/rtl/sst_datapath.sv
hw/rtl/sparse_set_table.sv
dv/tb_top.sv
